// File: sv/vsc_pkg.sv
package vsc_pkg;

    // field widths
    localparam int CH_W    = 8;
    localparam int COMP_W  = 32;
    localparam int ORD_W   = 2;
    localparam int PHASE_W = 3;
    localparam int ACC_EXT_W = COMP_W + 4;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - (1 + ORD_W + 3 * COMP_W);

    // apb
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register indexes (word address)
    localparam logic [1:0] REG_RUN_MAJOR = 2'd0;
    localparam logic [1:0] REG_RUN_MINOR = 2'd1;
    localparam logic [1:0] REG_RUN_PATCH = 2'd2;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_MAJOR = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MINOR = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PATCH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BAD   = 3'd4;

    // characters
    localparam logic [CH_W-1:0] CH_TERM  = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    localparam logic [COMP_W-1:0] SAT_MAX = 32'hFFFF_FFFF;

    // order codes
    localparam logic [ORD_W-1:0] ORD_OLDER = 2'b11;
    localparam logic [ORD_W-1:0] ORD_EQUAL = 2'b00;
    localparam logic [ORD_W-1:0] ORD_NEWER = 2'b01;

    // candidate handed from parser to result stage
    typedef struct packed {
        logic              ok;
        logic [COMP_W-1:0] major;
        logic [COMP_W-1:0] minor;
        logic [COMP_W-1:0] patch;
    } cand_t;

endpackage

// File: sv/vsc_parse.sv
module vsc_parse (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [vsc_pkg::CH_W-1:0] s_ch,
    output logic                     cand_valid,
    input  logic                     cand_ready,
    output vsc_pkg::cand_t           cand
);

    logic                        in_valid_reg, in_valid_next;
    logic [vsc_pkg::CH_W-1:0]    ch_reg;
    logic [vsc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        in_digits_reg, in_digits_next;
    logic [vsc_pkg::COMP_W-1:0]  acc_reg, acc_next;
    logic [vsc_pkg::COMP_W-1:0]  major_reg, major_next;
    logic [vsc_pkg::COMP_W-1:0]  minor_reg, minor_next;

    logic                          is_term;
    logic                          is_digit;
    logic                          consume;
    logic                          numeric;
    logic [vsc_pkg::ACC_EXT_W-1:0] acc_mac;
    logic [vsc_pkg::COMP_W-1:0]    acc_sat;

    // input register handshake
    assign is_term    = (ch_reg == vsc_pkg::CH_TERM);
    assign consume    = in_valid_reg && (!is_term || cand_ready);
    assign s_tready   = !in_valid_reg || consume;
    assign cand_valid = in_valid_reg && is_term;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_ch;
        end
    end

    // acc * 10 + digit, saturating
    assign is_digit = (ch_reg >= vsc_pkg::CH_ZERO) && (ch_reg <= vsc_pkg::CH_NINE);
    assign acc_mac  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {{(vsc_pkg::ACC_EXT_W - 4){1'b0}}, 4'(ch_reg - vsc_pkg::CH_ZERO)};
    assign acc_sat  = (acc_mac[vsc_pkg::ACC_EXT_W-1:vsc_pkg::COMP_W] != 4'd0)
                    ? vsc_pkg::SAT_MAX : acc_mac[vsc_pkg::COMP_W-1:0];
    assign numeric  = (phase_reg <= vsc_pkg::PH_PATCH);

    // candidate values seen on the terminator
    always_comb begin
        cand = '0;
        if (numeric && in_digits_reg) begin
            cand.ok = 1'b1;
            case (phase_reg)
                vsc_pkg::PH_MAJOR: begin
                    cand.major = acc_reg;
                end
                vsc_pkg::PH_MINOR: begin
                    cand.major = major_reg;
                    cand.minor = acc_reg;
                end
                default: begin
                    cand.major = major_reg;
                    cand.minor = minor_reg;
                    cand.patch = acc_reg;
                end
            endcase
        end else if (phase_reg == vsc_pkg::PH_DONE) begin
            cand.ok    = 1'b1;
            cand.major = major_reg;
            cand.minor = minor_reg;
            cand.patch = acc_reg;
        end
    end

    // parse state update per character
    always_comb begin
        phase_next     = phase_reg;
        in_digits_next = in_digits_reg;
        acc_next       = acc_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        if (consume) begin
            if (is_term) begin
                phase_next     = vsc_pkg::PH_MAJOR;
                in_digits_next = 1'b0;
                acc_next       = '0;
                major_next     = '0;
                minor_next     = '0;
            end else if (numeric) begin
                if (is_digit) begin
                    acc_next       = acc_sat;
                    in_digits_next = 1'b1;
                end else if (!in_digits_reg) begin
                    phase_next = vsc_pkg::PH_BAD;
                end else if ((ch_reg == vsc_pkg::CH_MINUS) || (ch_reg == vsc_pkg::CH_PLUS)
                             || ((ch_reg == vsc_pkg::CH_DOT)
                                 && (phase_reg == vsc_pkg::PH_PATCH))) begin
                    // numeric part ends here
                    if (phase_reg == vsc_pkg::PH_MAJOR) begin
                        major_next = acc_reg;
                        minor_next = '0;
                        acc_next   = '0;
                    end else if (phase_reg == vsc_pkg::PH_MINOR) begin
                        minor_next = acc_reg;
                        acc_next   = '0;
                    end
                    phase_next     = vsc_pkg::PH_DONE;
                    in_digits_next = 1'b0;
                end else if (ch_reg == vsc_pkg::CH_DOT) begin
                    // move on to the next component
                    if (phase_reg == vsc_pkg::PH_MAJOR) begin
                        major_next = acc_reg;
                        phase_next = vsc_pkg::PH_MINOR;
                    end else begin
                        minor_next = acc_reg;
                        phase_next = vsc_pkg::PH_PATCH;
                    end
                    acc_next       = '0;
                    in_digits_next = 1'b0;
                end else begin
                    phase_next = vsc_pkg::PH_BAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= vsc_pkg::PH_MAJOR;
            in_digits_reg <= 1'b0;
            acc_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            in_digits_reg <= in_digits_next;
            acc_reg       <= acc_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
        end
    end

`ifndef ASSERT_OFF
    // minor stays clear while the major is still being parsed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == vsc_pkg::PH_MAJOR) |-> (minor_reg == '0))
        else $error("minor value set during major phase");

    // a fresh component holds no value before its first digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (numeric && !in_digits_reg) |-> (acc_reg == '0))
        else $error("accumulator not clear at component start");

    // a delivered terminator returns the parser to its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && is_term) |=> ((phase_reg == vsc_pkg::PH_MAJOR) && !in_digits_reg
                                  && (major_reg == '0)))
        else $error("parse state not cleared after terminator");
`endif

endmodule

// File: sv/vsc_result.sv
module vsc_result (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cand_valid,
    output logic                       cand_ready,
    input  vsc_pkg::cand_t             cand,
    input  logic [vsc_pkg::COMP_W-1:0] run_major,
    input  logic [vsc_pkg::COMP_W-1:0] run_minor,
    input  logic [vsc_pkg::COMP_W-1:0] run_patch,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       res_ok,
    output logic [vsc_pkg::ORD_W-1:0]  res_order,
    output logic [vsc_pkg::COMP_W-1:0] res_major,
    output logic [vsc_pkg::COMP_W-1:0] res_minor,
    output logic [vsc_pkg::COMP_W-1:0] res_patch
);

    logic                       out_valid_reg, out_valid_next;
    logic                       ok_reg;
    logic [vsc_pkg::ORD_W-1:0]  order_reg, order_next;
    logic [vsc_pkg::COMP_W-1:0] major_reg, minor_reg, patch_reg;
    logic                       load;

    assign cand_ready = !out_valid_reg || m_tready;
    assign load       = cand_valid && cand_ready;

    // lexicographic compare against the running version
    always_comb begin
        order_next = vsc_pkg::ORD_EQUAL;
        if (cand.ok) begin
            if (cand.major != run_major) begin
                order_next = (cand.major < run_major) ? vsc_pkg::ORD_OLDER
                                                      : vsc_pkg::ORD_NEWER;
            end else if (cand.minor != run_minor) begin
                order_next = (cand.minor < run_minor) ? vsc_pkg::ORD_OLDER
                                                      : vsc_pkg::ORD_NEWER;
            end else if (cand.patch != run_patch) begin
                order_next = (cand.patch < run_patch) ? vsc_pkg::ORD_OLDER
                                                      : vsc_pkg::ORD_NEWER;
            end
        end
    end

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg    <= cand.ok;
            order_reg <= order_next;
            major_reg <= cand.major;
            minor_reg <= cand.minor;
            patch_reg <= cand.patch;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign res_ok    = ok_reg;
    assign res_order = order_reg;
    assign res_major = major_reg;
    assign res_minor = minor_reg;
    assign res_patch = patch_reg;

endmodule

// File: sv/version_string_compare_unit.sv
// version string compare: one character per stream item, zero ends the string
// a terminator is held in the input register until the result register loads its result
// throughput: one character per cycle unless a terminator waits for cand_ready
// the input register and the result register each let the next request in while full
// reset: aresetn low at a rising edge clears the parse state, the valid bits of both pipeline stages
// and the running version registers to zero

module version_string_compare_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // apb configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [vsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // character stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [vsc_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] ch
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] valid_res, [2:1] order, [34:3] cand_major, [66:35] cand_minor,
    // [98:67] cand_patch, [103:99] zero
    output logic [vsc_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [vsc_pkg::COMP_W-1:0] run_major_reg, run_major_next;
    logic [vsc_pkg::COMP_W-1:0] run_minor_reg, run_minor_next;
    logic [vsc_pkg::COMP_W-1:0] run_patch_reg, run_patch_next;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    logic                       cand_valid;
    logic                       cand_ready;
    vsc_pkg::cand_t             cand;

    logic                       res_ok;
    logic [vsc_pkg::ORD_W-1:0]  res_order;
    logic [vsc_pkg::COMP_W-1:0] res_major, res_minor, res_patch;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        run_major_next = run_major_reg;
        run_minor_next = run_minor_reg;
        run_patch_next = run_patch_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                vsc_pkg::REG_RUN_MAJOR: run_major_next = pwdata;
                vsc_pkg::REG_RUN_MINOR: run_minor_next = pwdata;
                vsc_pkg::REG_RUN_PATCH: run_patch_next = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_major_reg <= '0;
            run_minor_reg <= '0;
            run_patch_reg <= '0;
        end else begin
            run_major_reg <= run_major_next;
            run_minor_reg <= run_minor_next;
            run_patch_reg <= run_patch_next;
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            vsc_pkg::REG_RUN_MAJOR: prdata = run_major_reg;
            vsc_pkg::REG_RUN_MINOR: prdata = run_minor_reg;
            vsc_pkg::REG_RUN_PATCH: prdata = run_patch_reg;
            default:                prdata = '0;
        endcase
    end

    // character parser
    vsc_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_ch       (s_tdata[vsc_pkg::CH_W-1:0]),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand)
    );

    // compare and result register
    vsc_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand),
        .run_major  (run_major_reg),
        .run_minor  (run_minor_reg),
        .run_patch  (run_patch_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res_ok     (res_ok),
        .res_order  (res_order),
        .res_major  (res_major),
        .res_minor  (res_minor),
        .res_patch  (res_patch)
    );

    assign m_tdata = {{vsc_pkg::M_PAD_W{1'b0}}, res_patch, res_minor, res_major,
                      res_order, res_ok};

`ifndef ASSERT_OFF
    // a rejected string reports no order and no components
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res_ok) |-> ((res_order == vsc_pkg::ORD_EQUAL) && (res_major == '0)
                                   && (res_minor == '0) && (res_patch == '0)))
        else $error("rejected result carries data");

    // order is one of older, equal, newer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res_order == vsc_pkg::ORD_OLDER) || (res_order == vsc_pkg::ORD_EQUAL)
                      || (res_order == vsc_pkg::ORD_NEWER)))
        else $error("bad order code");

    // equal order means the components match the running version
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_ok && (res_order == vsc_pkg::ORD_EQUAL))
            |-> ((res_major == run_major_reg) && (res_minor == run_minor_reg)
                 && (res_patch == run_patch_reg)))
        else $error("equal order on differing version");
`endif

endmodule
